### rtl/kbe_pkg.sv
package kbe_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int AW    = XW + YW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int QDEPTH = 2;

	localparam logic [2:0] MODE_WRITE = 3'd0;
	localparam logic [2:0] MODE_READ  = 3'd1;
	localparam logic [2:0] MODE_FILL  = 3'd2;
	localparam logic [2:0] MODE_COPY  = 3'd3;
	localparam logic [2:0] MODE_KCOPY = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [2:0] REG_DW = 3'd0;
	localparam logic [2:0] REG_DH = 3'd1;
	localparam logic [2:0] REG_SW = 3'd2;
	localparam logic [2:0] REG_SH = 3'd3;
	localparam logic [2:0] REG_PS = 3'd4;
	localparam logic [2:0] REG_KV = 3'd5;
	localparam logic [2:0] REG_KE = 3'd6;

	typedef struct packed {
		logic [2:0]  mode;
		logic        surface_select;
		logic [8:0]  dst_left;
		logic [8:0]  dst_top;
		logic [8:0]  dst_right;
		logic [8:0]  dst_bottom;
		logic [8:0]  src_left;
		logic [8:0]  src_top;
		logic [8:0]  src_right;
		logic [8:0]  src_bottom;
		logic [31:0] pixel_value;
	} in_word_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  status;
		logic [31:0] change_count;
	} out_word_t;

	// Classified command handed from the front part to the back part.
	typedef enum logic [2:0] {
		OP_NONE, OP_WRITE, OP_READ, OP_FILL, OP_COPY
	} op_t;

	typedef struct packed {
		op_t         op;
		logic        sel;
		logic        keyed;
		logic [1:0]  status;
		logic        bump;
		logic [9:0]  dx;
		logic [9:0]  dy;
		logic [9:0]  sx;
		logic [9:0]  sy;
		logic [9:0]  cw;
		logic [9:0]  ch;
		logic [31:0] value;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_CLEAR, BK_RUN, BK_DRAIN, BK_RESULT
	} bk_state_t;

	function automatic logic [9:0] sat_dim(input logic [8:0] v, input int unsigned mx);
		logic [9:0] m;
		m = 10'(mx);
		sat_dim = ({1'b0, v} > m) ? m : {1'b0, v};
	endfunction

	function automatic logic [31:0] pix_mask(input logic [1:0] ps);
		case (ps)
			2'd0:    pix_mask = 32'h0000_00ff;
			2'd1:    pix_mask = 32'h0000_ffff;
			default: pix_mask = 32'hffff_ffff;
		endcase
	endfunction

endpackage

### rtl/kbe_ram.sv
module kbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/kbe_front.sv
module kbe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kbe_pkg::in_word_t in_word,
	input  logic [9:0]        dw,
	input  logic [9:0]        dh,
	input  logic [9:0]        sw,
	input  logic [9:0]        sh,
	input  logic              key_valid,
	input  logic [31:0]       mask,
	output logic              cmd_valid,
	output kbe_pkg::cmd_t     cmd,
	input  logic              cmd_pop
);

	kbe_pkg::cmd_t q_q [kbe_pkg::QDEPTH];
	logic [1:0] count_q;
	logic       wp_q, rp_q;
	kbe_pkg::cmd_t c;
	logic signed [10:0] cw0, ch0, cw1, ch1, cw2, ch2, cw3, ch3, cw4, ch4;
	logic signed [10:0] dl, dt, sl, st;
	logic [9:0] fr, fb;
	logic push;

	assign dl = 11'($unsigned(in_word.dst_left));
	assign dt = 11'($unsigned(in_word.dst_top));
	assign sl = 11'($unsigned(in_word.src_left));
	assign st = 11'($unsigned(in_word.src_top));

	// Copy size: smaller rectangle, then clipped to both surfaces; fill edges clipped to the destination.
	always_comb begin
		cw0 = 11'($unsigned(in_word.src_right)) - sl;
		cw1 = 11'($unsigned(in_word.dst_right)) - dl;
		ch0 = 11'($unsigned(in_word.src_bottom)) - st;
		ch1 = 11'($unsigned(in_word.dst_bottom)) - dt;
		cw2 = (cw0 < cw1) ? cw0 : cw1;
		ch2 = (ch0 < ch1) ? ch0 : ch1;
		cw3 = (dl + cw2 > $signed({1'b0, dw})) ? $signed({1'b0, dw}) - dl : cw2;
		ch3 = (dt + ch2 > $signed({1'b0, dh})) ? $signed({1'b0, dh}) - dt : ch2;
		cw4 = (sl + cw3 > $signed({1'b0, sw})) ? $signed({1'b0, sw}) - sl : cw3;
		ch4 = (st + ch3 > $signed({1'b0, sh})) ? $signed({1'b0, sh}) - st : ch3;
		fr = ({1'b0, in_word.dst_right} < dw) ? {1'b0, in_word.dst_right} : dw;
		fb = ({1'b0, in_word.dst_bottom} < dh) ? {1'b0, in_word.dst_bottom} : dh;
	end

	// Classify the word into a command for the back part.
	always_comb begin
		c = '0;
		c.op     = kbe_pkg::OP_NONE;
		c.sel    = in_word.surface_select;
		c.dx     = {1'b0, in_word.dst_left};
		c.dy     = {1'b0, in_word.dst_top};
		c.sx     = {1'b0, in_word.src_left};
		c.sy     = {1'b0, in_word.src_top};
		c.value  = in_word.pixel_value & mask;
		c.status = kbe_pkg::ST_DONE;
		case (in_word.mode)
			kbe_pkg::MODE_WRITE, kbe_pkg::MODE_READ: begin
				if ({1'b0, in_word.dst_left} >= (in_word.surface_select ? sw : dw) ||
				    {1'b0, in_word.dst_top} >= (in_word.surface_select ? sh : dh)) begin
					c.status = kbe_pkg::ST_RANGE;
				end else begin
					c.op   = (in_word.mode == kbe_pkg::MODE_WRITE) ?
					         kbe_pkg::OP_WRITE : kbe_pkg::OP_READ;
					c.bump = (in_word.mode == kbe_pkg::MODE_WRITE);
				end
			end
			kbe_pkg::MODE_FILL: begin
				c.bump = 1'b1;
				if (fr > {1'b0, in_word.dst_left} && fb > {1'b0, in_word.dst_top}) begin
					c.op = kbe_pkg::OP_FILL;
					c.cw = fr - {1'b0, in_word.dst_left};
					c.ch = fb - {1'b0, in_word.dst_top};
				end
			end
			kbe_pkg::MODE_COPY, kbe_pkg::MODE_KCOPY: begin
				if (cw4 <= 0 || ch4 <= 0) begin
					c.status = kbe_pkg::ST_EMPTY;
				end else begin
					c.op    = kbe_pkg::OP_COPY;
					c.bump  = 1'b1;
					c.keyed = (in_word.mode == kbe_pkg::MODE_KCOPY) && key_valid;
					c.cw    = cw4[9:0];
					c.ch    = ch4[9:0];
				end
			end
			default: ;
		endcase
	end

	assign busy = (count_q == 2'(kbe_pkg::QDEPTH));
	assign push = start && !busy;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd = q_q[rp_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= c;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wp_q    <= 1'b0;
			rp_q    <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop) begin
				rp_q <= ~rp_q;
			end
			count_q <= count_q + 2'(push) - 2'(cmd_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(kbe_pkg::QDEPTH)) else $error("queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid) else $error("pop from empty queue");
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'(kbe_pkg::QDEPTH)) |-> busy) else $error("full but not busy");

endmodule

### rtl/kbe_back.sv
module kbe_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  kbe_pkg::cmd_t      cmd,
	output logic               cmd_pop,
	input  logic [31:0]        mask,
	input  logic [31:0]        key_value,
	output logic               done,
	output kbe_pkg::out_word_t result
);

	kbe_pkg::bk_state_t state_q, state_d;
	kbe_pkg::cmd_t      cur_q;
	logic [9:0]  xi_q, yi_q;
	logic [kbe_pkg::AW-1:0] clr_q;
	logic [31:0] cnt_q;
	logic [31:0] rdata_q;
	// Copy write pending from the registered source read.
	logic        pend_s1;
	logic [kbe_pkg::AW-1:0] paddr_s1;

	logic d_we, s_we;
	logic [kbe_pkg::AW-1:0] d_wa, s_wa, d_ra, s_ra;
	logic [31:0] d_wd, s_wd, d_rd, s_rd, srcpix;
	logic last;
	logic [9:0] ax, ay, bx, by;

	kbe_ram #(.WIDTH(32), .DEPTH(kbe_pkg::DEPTH)) u_dst (
		.clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
	kbe_ram #(.WIDTH(32), .DEPTH(kbe_pkg::DEPTH)) u_src (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	assign ax = cur_q.dx + xi_q;
	assign ay = cur_q.dy + yi_q;
	assign bx = cur_q.sx + xi_q;
	assign by = cur_q.sy + yi_q;
	assign last = (xi_q == cur_q.cw - 10'd1) && (yi_q == cur_q.ch - 10'd1);
	assign srcpix = s_rd & mask;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			kbe_pkg::BK_CLEAR:  if (&clr_q) state_d = kbe_pkg::BK_IDLE;
			kbe_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					if (cmd.op == kbe_pkg::OP_FILL || cmd.op == kbe_pkg::OP_COPY ||
					    cmd.op == kbe_pkg::OP_READ) begin
						state_d = kbe_pkg::BK_RUN;
					end else begin
						state_d = kbe_pkg::BK_RESULT;
					end
				end
			end
			kbe_pkg::BK_RUN: begin
				if (cur_q.op == kbe_pkg::OP_READ) state_d = kbe_pkg::BK_RESULT;
				else if (last) state_d = (cur_q.op == kbe_pkg::OP_COPY) ?
				                         kbe_pkg::BK_DRAIN : kbe_pkg::BK_RESULT;
			end
			kbe_pkg::BK_DRAIN:  state_d = kbe_pkg::BK_RESULT;
			kbe_pkg::BK_RESULT: state_d = kbe_pkg::BK_IDLE;
			default:            state_d = kbe_pkg::BK_IDLE;
		endcase
	end

	// Memory ports and handshake outputs.
	always_comb begin
		cmd_pop = (state_q == kbe_pkg::BK_IDLE) && cmd_valid;
		d_we = 1'b0; s_we = 1'b0;
		d_wa = {ay[kbe_pkg::YW-1:0], ax[kbe_pkg::XW-1:0]};
		s_wa = d_wa;
		d_wd = cur_q.value; s_wd = cur_q.value;
		d_ra = {cmd.dy[kbe_pkg::YW-1:0], cmd.dx[kbe_pkg::XW-1:0]};
		s_ra = {by[kbe_pkg::YW-1:0], bx[kbe_pkg::XW-1:0]};
		if (state_q == kbe_pkg::BK_CLEAR) begin
			d_we = 1'b1; s_we = 1'b1;
			d_wa = clr_q; s_wa = clr_q;
			d_wd = '0; s_wd = '0;
		end else if (state_q == kbe_pkg::BK_IDLE && cmd_valid &&
		             cmd.op == kbe_pkg::OP_WRITE) begin
			d_wa = {cmd.dy[kbe_pkg::YW-1:0], cmd.dx[kbe_pkg::XW-1:0]};
			s_wa = d_wa;
			d_wd = cmd.value; s_wd = cmd.value;
			d_we = !cmd.sel; s_we = cmd.sel;
		end else if (state_q == kbe_pkg::BK_RUN && cur_q.op == kbe_pkg::OP_FILL) begin
			d_we = 1'b1;
		end
		if (state_q == kbe_pkg::BK_IDLE && cmd_valid && cmd.op == kbe_pkg::OP_READ) begin
			s_ra = d_ra;
		end
		if (pend_s1) begin
			d_wa = paddr_s1;
			d_wd = srcpix;
			d_we = !cur_q.keyed || (srcpix != key_value);
		end
		done = (state_q == kbe_pkg::BK_RESULT);
		result.read_data    = (cur_q.op == kbe_pkg::OP_READ) ? rdata_q : 32'd0;
		result.status       = cur_q.status;
		result.change_count = cnt_q;
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kbe_pkg::BK_CLEAR;
			clr_q   <= '0;
			xi_q    <= '0;
			yi_q    <= '0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == kbe_pkg::BK_RUN) && (cur_q.op == kbe_pkg::OP_COPY);
			if (state_q == kbe_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (cmd_pop) begin
				xi_q <= '0;
				yi_q <= '0;
				if (cmd.bump) cnt_q <= cnt_q + 32'd1;
			end else if (state_q == kbe_pkg::BK_RUN) begin
				if (xi_q == cur_q.cw - 10'd1) begin
					xi_q <= '0;
					yi_q <= yi_q + 10'd1;
				end else begin
					xi_q <= xi_q + 10'd1;
				end
			end
		end
	end

	// Command, pending address and read data.
	always_ff @(posedge clk) begin
		if (cmd_pop) cur_q <= cmd;
		paddr_s1 <= {ay[kbe_pkg::YW-1:0], ax[kbe_pkg::XW-1:0]};
		if (state_q == kbe_pkg::BK_RUN && cur_q.op == kbe_pkg::OP_READ) begin
			rdata_q <= (cur_q.sel ? s_rd : d_rd) & mask;
		end
	end

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> state_q == kbe_pkg::BK_IDLE) else $error("pop while busy");
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held over two cycles");
	a_pend_copy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> cur_q.op == kbe_pkg::OP_COPY) else $error("stray copy write");

endmodule

### rtl/keyed_blit_engine_core.sv
// Keyed blit engine: host pixel access, rectangle fill and keyed copy.
// Commands enter on start when busy is low; the word in in_word is taken at
// that edge. A two-entry command queue lets the host issue a second command
// while the first is being carried out.
// Each command gives one result word on result, marked by done for exactly
// one cycle; the receiver cannot stall and must take it then.
// In the back part a pixel write or an unserviced mode goes straight to
// the result, a read passes through the run state, a fill writes its
// clipped w*h rectangle in the run state and a copy adds a drain state;
// the single write port of the destination store, one pixel a cycle, paces fills and copies.
// Configuration words arrive on cfg_valid/cfg_ready with cfg_index and
// cfg_data and must only be written while the engine is idle.
// After reset both pixel stores are cleared, one pixel a cycle through every
// location, during which busy stays high once the queue fills and no command
// completes; configuration writes are taken as ever.
module keyed_blit_engine_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  kbe_pkg::in_word_t   in_word,
	output logic                done,
	output kbe_pkg::out_word_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	logic [8:0]  dw_q, dh_q, sw_q, sh_q;
	logic [1:0]  ps_q;
	logic [31:0] kv_q;
	logic        ke_q;
	logic        cmd_valid, cmd_pop;
	kbe_pkg::cmd_t cmd;
	logic [31:0] mask;

	assign cfg_ready = 1'b1;
	assign mask = kbe_pkg::pix_mask(ps_q);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_q <= 9'd256; dh_q <= 9'd256; sw_q <= 9'd256; sh_q <= 9'd256;
			ps_q <= '0; kv_q <= '0; ke_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				kbe_pkg::REG_DW: dw_q <= cfg_data[8:0];
				kbe_pkg::REG_DH: dh_q <= cfg_data[8:0];
				kbe_pkg::REG_SW: sw_q <= cfg_data[8:0];
				kbe_pkg::REG_SH: sh_q <= cfg_data[8:0];
				kbe_pkg::REG_PS: ps_q <= cfg_data[1:0];
				kbe_pkg::REG_KV: kv_q <= cfg_data;
				kbe_pkg::REG_KE: ke_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	kbe_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.dw(kbe_pkg::sat_dim(dw_q, kbe_pkg::MAX_WIDTH)),
		.dh(kbe_pkg::sat_dim(dh_q, kbe_pkg::MAX_HEIGHT)),
		.sw(kbe_pkg::sat_dim(sw_q, kbe_pkg::MAX_WIDTH)),
		.sh(kbe_pkg::sat_dim(sh_q, kbe_pkg::MAX_HEIGHT)),
		.key_valid(ke_q), .mask(mask),
		.cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

	kbe_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
		.mask(mask), .key_value(kv_q), .done(done), .result(result));

endmodule

### tb/sv/keyed_blit_engine_core_tb.sv
`timescale 1ns / 100ps

// Keeps its own copy of both pixel stores and the registers, works out the
// result word of every accepted command and checks the words that come back.
class blit_scoreboard;
	logic [31:0] dest_px [kbe_pkg::DEPTH];
	logic [31:0] src_px [kbe_pkg::DEPTH];
	logic [31:0] changes;
	logic [8:0]  dest_w, dest_h, src_w, src_h;
	logic [1:0]  pix_size;
	logic [31:0] key_value;
	logic        key_valid;
	kbe_pkg::out_word_t expected_words [$];
	int          errors;

	function new();
		foreach (dest_px[i]) begin
			dest_px[i] = '0;
			src_px[i]  = '0;
		end
		changes   = '0;
		dest_w    = 9'd256;
		dest_h    = 9'd256;
		src_w     = 9'd256;
		src_h     = 9'd256;
		pix_size  = 2'd0;
		key_value = '0;
		key_valid = 1'b0;
		errors    = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [31:0] d);
		case (idx)
			kbe_pkg::REG_DW: dest_w = d[8:0];
			kbe_pkg::REG_DH: dest_h = d[8:0];
			kbe_pkg::REG_SW: src_w = d[8:0];
			kbe_pkg::REG_SH: src_h = d[8:0];
			kbe_pkg::REG_PS: pix_size = d[1:0];
			kbe_pkg::REG_KV: key_value = d;
			kbe_pkg::REG_KE: key_valid = d[0];
			default: ;
		endcase
	endfunction

	function int clamp(logic [8:0] v, int mx);
		return (int'(v) > mx) ? mx : int'(v);
	endfunction

	// Carries out one command on the local stores and queues its result word.
	function void note_command(kbe_pkg::in_word_t w);
		kbe_pkg::out_word_t r;
		logic [31:0] m;
		logic [31:0] p;
		int dl, dt, dr, db, sl, st, sr, sb;
		int dw, dh, sw, sh, cw, ch, lim_w, lim_h;
		bit keyed;
		m  = (pix_size == 2'd0) ? 32'hff : (pix_size == 2'd1) ? 32'hffff : 32'hffff_ffff;
		dl = w.dst_left;  dt = w.dst_top;  dr = w.dst_right; db = w.dst_bottom;
		sl = w.src_left;  st = w.src_top;  sr = w.src_right; sb = w.src_bottom;
		dw = clamp(dest_w, kbe_pkg::MAX_WIDTH);
		dh = clamp(dest_h, kbe_pkg::MAX_HEIGHT);
		sw = clamp(src_w, kbe_pkg::MAX_WIDTH);
		sh = clamp(src_h, kbe_pkg::MAX_HEIGHT);
		r.read_data = '0;
		r.status    = kbe_pkg::ST_DONE;
		case (w.mode)
			kbe_pkg::MODE_WRITE, kbe_pkg::MODE_READ: begin
				lim_w = w.surface_select ? sw : dw;
				lim_h = w.surface_select ? sh : dh;
				if (dl >= lim_w || dt >= lim_h) begin
					r.status = kbe_pkg::ST_RANGE;
				end else if (w.mode == kbe_pkg::MODE_WRITE) begin
					if (w.surface_select)
						src_px[dt * kbe_pkg::MAX_WIDTH + dl] = w.pixel_value & m;
					else
						dest_px[dt * kbe_pkg::MAX_WIDTH + dl] = w.pixel_value & m;
					changes++;
				end else begin
					r.read_data = (w.surface_select ? src_px[dt * kbe_pkg::MAX_WIDTH + dl]
						: dest_px[dt * kbe_pkg::MAX_WIDTH + dl]) & m;
				end
			end
			kbe_pkg::MODE_FILL: begin
				for (int y = dt; y < db && y < dh; y++)
					for (int x = dl; x < dr && x < dw; x++)
						dest_px[y * kbe_pkg::MAX_WIDTH + x] = w.pixel_value & m;
				changes++;
			end
			kbe_pkg::MODE_COPY, kbe_pkg::MODE_KCOPY: begin
				cw = (sr - sl) < (dr - dl) ? (sr - sl) : (dr - dl);
				ch = (sb - st) < (db - dt) ? (sb - st) : (db - dt);
				keyed = (w.mode == kbe_pkg::MODE_KCOPY) && key_valid;
				if (dl + cw > dw) cw = dw - dl;
				if (dt + ch > dh) ch = dh - dt;
				if (sl + cw > sw) cw = sw - sl;
				if (st + ch > sh) ch = sh - st;
				if (cw <= 0 || ch <= 0) begin
					r.status = kbe_pkg::ST_EMPTY;
				end else begin
					for (int y = 0; y < ch; y++)
						for (int x = 0; x < cw; x++) begin
							p = src_px[(st + y) * kbe_pkg::MAX_WIDTH + sl + x] & m;
							if (!keyed || p != key_value)
								dest_px[(dt + y) * kbe_pkg::MAX_WIDTH + dl + x] = p;
						end
					changes++;
				end
			end
			default: ;
		endcase
		r.change_count = changes;
		expected_words.push_back(r);
	endfunction

	function void check_result(kbe_pkg::out_word_t got);
		kbe_pkg::out_word_t e;
		if (expected_words.size() == 0) begin
			$error("result word with no command outstanding: %h", got);
			errors++;
			return;
		end
		e = expected_words.pop_front();
		if (got.read_data !== e.read_data) begin
			$error("read_data: expected %h, got %h", e.read_data, got.read_data);
			errors++;
		end
		if (got.status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, got.status);
			errors++;
		end
		if (got.change_count !== e.change_count) begin
			$error("change_count: expected %0d, got %0d", e.change_count, got.change_count);
			errors++;
		end
	endfunction
endclass

module keyed_blit_engine_core_tb;
	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 135;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	kbe_pkg::in_word_t  in_word;
	logic      done;
	kbe_pkg::out_word_t result;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	blit_scoreboard sb;
	int cycles;
	logic [31:0] palette [6] = '{32'h0, 32'h1, 32'hff, 32'hffff, 32'hffff_ffff, 32'h1234_5678};

	keyed_blit_engine_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_word(in_word),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result words are taken at the edge that ends their strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Issues one command word after a random idle gap, which may be zero, and waits until it is taken.
	task automatic send_command(kbe_pkg::in_word_t w);
		int gap;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (busy);
		sb.note_command(w);
	endtask

	// Writes one register, then leaves the channel idle.
	task automatic write_reg(logic [2:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, d);
		@(posedge clk);
	endtask

	// Lets the engine drain so that registers may be written safely.
	task automatic wait_idle();
		start <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic kbe_pkg::in_word_t make_cmd(logic [2:0] mode, logic sel,
		int dl, int dt, int dr, int db, int sl, int st, int sr, int sb_, logic [31:0] v);
		kbe_pkg::in_word_t w;
		w.mode = mode;          w.surface_select = sel;
		w.dst_left = 9'(dl);    w.dst_top = 9'(dt);
		w.dst_right = 9'(dr);   w.dst_bottom = 9'(db);
		w.src_left = 9'(sl);    w.src_top = 9'(st);
		w.src_right = 9'(sr);   w.src_bottom = 9'(sb_);
		w.pixel_value = v;
		return w;
	endfunction

	// Coordinates cluster near the origin so that writes, fills and copies overlap.
	function automatic int rnd_coord();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70) return $urandom_range(0, 15);
		if (k < 90) return $urandom_range(0, 256);
		return $urandom_range(0, 511);
	endfunction

	function automatic int rnd_edge(int lo);
		int k;
		k = $urandom_range(0, 99);
		if (k < 1) return $urandom_range(0, 511);
		if (k < 10) return lo - $urandom_range(0, 5);
		return lo + $urandom_range(0, 7);
	endfunction

	function automatic logic [31:0] rnd_pixel();
		if ($urandom_range(0, 1)) return palette[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	function automatic logic [8:0] rnd_size();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4) return 9'($urandom_range(1, 16));
		if (k < 6) return 9'd256;
		if (k == 6) return 9'd1;
		if (k == 7) return 9'd0;
		if (k == 8) return 9'($urandom_range(257, 511));
		return 9'($urandom_range(1, 256));
	endfunction

	function automatic kbe_pkg::in_word_t rnd_cmd();
		int k, dl, dt, sl, st;
		logic [2:0] mode;
		k = $urandom_range(0, 99);
		if (k < 30)      mode = kbe_pkg::MODE_WRITE;
		else if (k < 52) mode = kbe_pkg::MODE_READ;
		else if (k < 67) mode = kbe_pkg::MODE_FILL;
		else if (k < 80) mode = kbe_pkg::MODE_COPY;
		else if (k < 95) mode = kbe_pkg::MODE_KCOPY;
		else             mode = 3'($urandom_range(5, 7));
		dl = rnd_coord(); dt = rnd_coord(); sl = rnd_coord(); st = rnd_coord();
		return make_cmd(mode, 1'($urandom_range(0, 1)), dl, dt, rnd_edge(dl), rnd_edge(dt),
			sl, st, rnd_edge(sl), rnd_edge(st), rnd_pixel());
	endfunction

	initial begin
		sb = new();
		cycles    = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		in_word   = '0;
		cfg_valid = 1'b0;
		cfg_index = kbe_pkg::REG_DW;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the full surface size, eight-bit pixels.
		send_command(make_cmd(kbe_pkg::MODE_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'haabb_ccdd));
		send_command(make_cmd(kbe_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(kbe_pkg::MODE_WRITE, 1, 255, 255, 0, 0, 0, 0, 0, 0,
			32'h5566_7788));
		send_command(make_cmd(kbe_pkg::MODE_READ, 1, 255, 255, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(kbe_pkg::MODE_WRITE, 1, 256, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff));
		send_command(make_cmd(kbe_pkg::MODE_READ, 0, 0, 511, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(3'd5, 0, 1, 1, 2, 2, 0, 0, 1, 1, 32'h1));
		send_command(make_cmd(3'd6, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(kbe_pkg::MODE_FILL, 0, 2, 2, 6, 5, 0, 0, 0, 0, 32'h1234_56ff));
		send_command(make_cmd(kbe_pkg::MODE_FILL, 0, 6, 6, 2, 2, 0, 0, 0, 0, 32'h77));
		send_command(make_cmd(kbe_pkg::MODE_FILL, 0, 250, 250, 511, 511, 0, 0, 0, 0, 32'h99));
		send_command(make_cmd(kbe_pkg::MODE_COPY, 0, 10, 10, 14, 12, 250, 250, 260, 260, 0));
		send_command(make_cmd(kbe_pkg::MODE_COPY, 0, 5, 5, 5, 9, 0, 0, 4, 4, 0));
		send_command(make_cmd(kbe_pkg::MODE_KCOPY, 0, 20, 20, 30, 30, 0, 0, 8, 8, 0));
		send_command(make_cmd(kbe_pkg::MODE_FILL, 0, 0, 0, 256, 256, 0, 0, 0, 0, 32'hc3));
		send_command(make_cmd(kbe_pkg::MODE_COPY, 0, 0, 0, 256, 256, 0, 0, 511, 511, 0));
		send_command(make_cmd(kbe_pkg::MODE_READ, 0, 255, 255, 0, 0, 0, 0, 0, 0, 0));
		wait_idle();

		// Keyed copy with the key in force, wide pixels, a small source surface.
		write_reg(kbe_pkg::REG_PS, 32'd3);
		write_reg(kbe_pkg::REG_KV, 32'h0000_0077);
		write_reg(kbe_pkg::REG_KE, 32'd1);
		write_reg(kbe_pkg::REG_SW, 32'd4);
		write_reg(kbe_pkg::REG_SH, 32'd4);
		write_reg(kbe_pkg::REG_DW, 32'd300);
		write_reg(kbe_pkg::REG_DH, 32'd0);
		send_command(make_cmd(kbe_pkg::MODE_WRITE, 1, 1, 1, 0, 0, 0, 0, 0, 0, 32'h77));
		send_command(make_cmd(kbe_pkg::MODE_WRITE, 1, 2, 1, 0, 0, 0, 0, 0, 0, 32'hdead_beef));
		send_command(make_cmd(kbe_pkg::MODE_KCOPY, 0, 0, 0, 4, 4, 0, 0, 4, 4, 0));
		send_command(make_cmd(kbe_pkg::MODE_FILL, 0, 0, 0, 4, 4, 0, 0, 0, 0, 32'h1));
		wait_idle();
		write_reg(kbe_pkg::REG_DH, 32'd8);
		send_command(make_cmd(kbe_pkg::MODE_KCOPY, 0, 0, 0, 4, 4, 0, 0, 4, 4, 0));
		send_command(make_cmd(kbe_pkg::MODE_READ, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(kbe_pkg::MODE_READ, 0, 2, 1, 0, 0, 0, 0, 0, 0, 0));
		wait_idle();

		// Random phases, each under a fresh register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(kbe_pkg::REG_DW, 32'(rnd_size()));
			write_reg(kbe_pkg::REG_DH, 32'(rnd_size()));
			write_reg(kbe_pkg::REG_SW, 32'(rnd_size()));
			write_reg(kbe_pkg::REG_SH, 32'(rnd_size()));
			write_reg(kbe_pkg::REG_PS, 32'(ph % 4));
			write_reg(kbe_pkg::REG_KV, (ph == 5) ? $urandom : palette[$urandom_range(0, 5)]);
			write_reg(kbe_pkg::REG_KE, 32'(ph % 3 != 0));
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_command(rnd_cmd());
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.expected_words.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
